@@ rtl/core/tcw_pkg.sv @@
// Shared constants, codes and controller/datapath types for the console writer.
package tcw_pkg;

    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_COLS  = 80;
    localparam int CELLS        = SCREEN_ROWS * SCREEN_COLS;
    localparam int CELL_AW      = $clog2(CELLS);
    localparam int CURSOR_PITCH = 80;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 11;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    // row + column sums and the scaled row fit here with room to spare
    localparam int SUM_W      = 14;

    localparam logic [CHAR_W-1:0] BLANK  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // tab stops every four columns: low two bits of the column
    localparam int TAB_BITS = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP    = 3'd0,
        CFG_LEFT   = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3,
        CFG_ENABLE = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_PUT,
        ST_TAB,
        ST_FIX,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BOTTOM,
        ST_CLEAR,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SEL_CURSOR,
        SEL_READ,
        SEL_SRC,
        SEL_DST
    } t_sel;

    typedef enum logic [1:0] {
        WSRC_CHAR,
        WSRC_BLANK,
        WSRC_COPY
    } t_wsrc;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_CLAMP,
        CUR_BS,
        CUR_INC,
        CUR_NL,
        CUR_FIX,
        CUR_HOME
    } t_cur_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_NEXT,
        CNT_BOTTOM
    } t_cnt_op;

    typedef enum logic [1:0] {
        CHR_TEXT,
        CHR_BS,
        CHR_TAB,
        CHR_NL
    } t_chr;

    typedef struct packed {
        logic    capture;
        logic    init_wr;
        t_sel    sel;
        logic    rd;
        logic    wr;
        t_wsrc   wsrc;
        t_cur_op cur_op;
        t_cnt_op cnt_op;
        logic    latch_rd;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic  init_last;
        t_func func;
        logic  enable;
        t_chr  chr;
        logic  tab_more;
        logic  need_scroll;
        logic  h_one;
        logic  col_last;
        logic  row_last;
        logic  scr_last;
        logic  out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tcw_ctrl.sv @@
// Command sequencer for the console writer: walks put, read, clear and scroll.
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd o_cmd
);
    import tcw_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.sel      = SEL_CURSOR;
        cmd.wsrc     = WSRC_BLANK;
        cmd.cur_op   = CUR_HOLD;
        cmd.cnt_op   = CNT_HOLD;
        case (r_state)
            ST_INIT: begin
                // blank the whole store once after reset
                cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_sts.func)
                    FUNC_PUT: begin
                        if (i_sts.enable) begin
                            cmd.cur_op = CUR_CLAMP;
                            n_state    = ST_PUT;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    FUNC_READ: begin
                        cmd.sel = SEL_READ;
                        cmd.rd  = 1'b1;
                        n_state = ST_RD_WAIT;
                    end
                    FUNC_CLEAR: begin
                        if (i_sts.enable) begin
                            cmd.cnt_op = CNT_ZERO;
                            n_state    = ST_CLEAR;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_RD_WAIT: begin
                cmd.latch_rd = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_PUT: begin
                case (i_sts.chr)
                    CHR_BS: begin
                        cmd.cur_op = CUR_BS;
                        n_state    = ST_FIX;
                    end
                    CHR_TAB: n_state = ST_TAB;
                    CHR_NL: begin
                        cmd.cur_op = CUR_NL;
                        n_state    = ST_FIX;
                    end
                    default: begin
                        cmd.sel    = SEL_CURSOR;
                        cmd.wr     = 1'b1;
                        cmd.wsrc   = WSRC_CHAR;
                        cmd.cur_op = CUR_INC;
                        n_state    = ST_FIX;
                    end
                endcase
            end
            ST_TAB: begin
                cmd.sel    = SEL_CURSOR;
                cmd.wr     = 1'b1;
                cmd.wsrc   = WSRC_BLANK;
                cmd.cur_op = CUR_INC;
                if (!i_sts.tab_more) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.cur_op = CUR_FIX;
                if (i_sts.need_scroll) begin
                    if (i_sts.h_one) begin
                        cmd.cnt_op = CNT_BOTTOM;
                        n_state    = ST_BOTTOM;
                    end else begin
                        cmd.cnt_op = CNT_ZERO;
                        n_state    = ST_SCR_RD;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCR_RD: begin
                cmd.sel = SEL_SRC;
                cmd.rd  = 1'b1;
                n_state = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                cmd.sel  = SEL_DST;
                cmd.wr   = 1'b1;
                cmd.wsrc = WSRC_COPY;
                if (i_sts.col_last && i_sts.scr_last) begin
                    cmd.cnt_op = CNT_BOTTOM;
                    n_state    = ST_BOTTOM;
                end else begin
                    cmd.cnt_op = CNT_NEXT;
                    n_state    = ST_SCR_RD;
                end
            end
            ST_BOTTOM: begin
                cmd.sel    = SEL_DST;
                cmd.wr     = 1'b1;
                cmd.wsrc   = WSRC_BLANK;
                cmd.cnt_op = CNT_NEXT;
                if (i_sts.col_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_CLEAR: begin
                cmd.sel    = SEL_DST;
                cmd.wr     = 1'b1;
                cmd.wsrc   = WSRC_BLANK;
                cmd.cnt_op = CNT_NEXT;
                if (i_sts.col_last && i_sts.row_last) begin
                    cmd.cur_op = CUR_HOME;
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == ST_IDLE);

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is still in work");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken word");

    a_load_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_in_ready)
        else $error("sequencer not idle after result load");

endmodule

@@ rtl/core/tcw_dp.sv @@
// Console writer datapath: window registers, cursor, sweep counters, cell store, result.
module tcw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [tcw_pkg::FUNC_W-1:0]       i_func,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]        i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]        i_read_col,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [tcw_pkg::POS_W-1:0]        o_cursor_pos,
    output logic [tcw_pkg::ROW_W-1:0]        o_cursor_line,
    output logic [tcw_pkg::COL_W-1:0]        o_cursor_column,
    output logic [tcw_pkg::CHAR_W-1:0]       o_read_char,
    output logic                             o_scrolled,
    input  tcw_pkg::t_dp_cmd                 i_cmd,
    output tcw_pkg::t_dp_sts                 o_sts
);
    import tcw_pkg::*;

    // window registers
    logic [ROW_W-1:0] r_top;
    logic [COL_W-1:0] r_left;
    logic [COL_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    logic             r_enable;

    // cursor and captured command
    logic [ROW_W-1:0]  r_cy, n_cy;
    logic [COL_W-1:0]  r_cx, n_cx;
    t_func             r_func;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_rrow;
    logic [COL_W-1:0]  r_rcol;

    // sweep counters
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [CELL_AW-1:0] r_clr_addr;

    logic              r_rd_blank;
    logic [CHAR_W-1:0] r_rd;
    logic              r_scrolled;

    // result register
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [ROW_W-1:0]  r_out_line;
    logic [COL_W-1:0]  r_out_col;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_scrolled;

    logic [COL_W-1:0]   ew;
    logic [ROW_W-1:0]   eh;
    logic [ROW_W:0]     a_row;
    logic [COL_W-1:0]   a_col;
    logic [ROW_W+1:0]   abs_row;
    logic [COL_W:0]     abs_col;
    logic               off;
    logic               win_ok;
    logic [SUM_W-1:0]   addr_full;
    logic [CELL_AW-1:0] cell_addr;
    logic [SUM_W-1:0]   pos_full;
    logic               x_wrap;
    logic [ROW_W:0]     y_next;
    logic               need_scroll;
    logic [COL_W:0]     x_inc;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic [CHAR_W-1:0]  ram_rdata;
    logic [CHAR_W-1:0]  fetched;

    assign ew = (r_width  == '0) ? COL_W'(1) : r_width;
    assign eh = (r_height == '0) ? ROW_W'(1) : r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_left   <= '0;
            r_width  <= COL_W'(80);
            r_height <= ROW_W'(24);
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TOP:    r_top    <= i_cfg_data[ROW_W-1:0];
                CFG_LEFT:   r_left   <= i_cfg_data[COL_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[COL_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // one shared cell address unit; source picked by the sequencer
    always_comb begin
        case (i_cmd.sel)
            SEL_CURSOR: begin
                a_row = {1'b0, r_cy};
                a_col = r_cx;
            end
            SEL_READ: begin
                a_row = {1'b0, r_rrow};
                a_col = r_rcol;
            end
            SEL_SRC: begin
                a_row = {1'b0, r_row} + (ROW_W+1)'(1);
                a_col = r_col;
            end
            default: begin
                a_row = {1'b0, r_row};
                a_col = r_col;
            end
        endcase
    end

    assign abs_row   = (ROW_W+2)'(r_top) + (ROW_W+2)'(a_row);
    assign abs_col   = (COL_W+1)'(r_left) + (COL_W+1)'(a_col);
    assign off       = (abs_row >= (ROW_W+2)'(SCREEN_ROWS)) ||
                       (abs_col >= (COL_W+1)'(SCREEN_COLS));
    assign addr_full = SUM_W'(abs_row) * SUM_W'(SCREEN_COLS) + SUM_W'(abs_col);
    assign cell_addr = addr_full[CELL_AW-1:0];
    assign win_ok    = (r_rrow < eh) && (r_rcol < ew);

    assign pos_full = (SUM_W'(r_top) + SUM_W'(r_cy)) * SUM_W'(CURSOR_PITCH)
                    + SUM_W'(r_left) + SUM_W'(r_cx);

    assign x_wrap      = (r_cx >= ew);
    assign y_next      = {1'b0, r_cy} + {{ROW_W{1'b0}}, x_wrap};
    assign need_scroll = (y_next >= {1'b0, eh});
    assign x_inc       = {1'b0, r_cx} + (COL_W+1)'(1);

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        case (i_cmd.cur_op)
            CUR_CLAMP: begin
                if (r_cx >= ew) begin
                    n_cx = ew - COL_W'(1);
                end
                if (r_cy >= eh) begin
                    n_cy = eh - ROW_W'(1);
                end
            end
            CUR_BS: begin
                if (r_cx != '0) begin
                    n_cx = r_cx - COL_W'(1);
                end
            end
            CUR_INC: n_cx = x_inc[COL_W-1:0];
            CUR_NL: begin
                n_cx = '0;
                n_cy = r_cy + ROW_W'(1);
            end
            CUR_FIX: begin
                n_cx = x_wrap ? '0 : r_cx;
                n_cy = need_scroll ? (eh - ROW_W'(1)) : y_next[ROW_W-1:0];
            end
            CUR_HOME: begin
                n_cx = '0;
                n_cy = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (i_cmd.cnt_op)
            CNT_ZERO: begin
                n_row = '0;
                n_col = '0;
            end
            CNT_NEXT: begin
                if (r_col == ew - COL_W'(1)) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            CNT_BOTTOM: begin
                n_row = eh - ROW_W'(1);
                n_col = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy        <= '0;
            r_cx        <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cy <= n_cy;
            r_cx <= n_cx;
            if (i_cmd.init_wr) begin
                r_clr_addr <= r_clr_addr + CELL_AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        if (i_cmd.capture) begin
            r_func     <= t_func'(i_func);
            r_char     <= i_char_code;
            r_rrow     <= i_read_row;
            r_rcol     <= i_read_col;
            r_rd       <= '0;
            r_scrolled <= 1'b0;
        end
        if (i_cmd.rd) begin
            r_rd_blank <= off || ((i_cmd.sel == SEL_READ) && !win_ok);
        end
        if (i_cmd.latch_rd) begin
            r_rd <= fetched;
        end
        if ((i_cmd.cur_op == CUR_FIX) && need_scroll) begin
            r_scrolled <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_pos      <= pos_full[POS_W-1:0];
            r_out_line     <= r_cy;
            r_out_col      <= r_cx;
            r_out_char     <= r_rd;
            r_out_scrolled <= r_scrolled;
        end
    end

    // cells off the screen read as blank and drop writes
    assign fetched = r_rd_blank ? BLANK : ram_rdata;

    always_comb begin
        ram_we    = i_cmd.init_wr || (i_cmd.wr && !off);
        ram_waddr = i_cmd.init_wr ? r_clr_addr : cell_addr;
        case (i_cmd.wsrc)
            WSRC_CHAR: ram_wdata = r_char;
            WSRC_COPY: ram_wdata = fetched;
            default:   ram_wdata = BLANK;
        endcase
        if (i_cmd.init_wr) begin
            ram_wdata = BLANK;
        end
    end

    tcw_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(cell_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_sts.init_last   = (r_clr_addr == CELL_AW'(CELLS - 1));
        o_sts.func        = r_func;
        o_sts.enable      = r_enable;
        if (r_char == CH_BS) begin
            o_sts.chr = CHR_BS;
        end else if (r_char == CH_TAB) begin
            o_sts.chr = CHR_TAB;
        end else if (r_char inside {CH_LF, CH_CR}) begin
            o_sts.chr = CHR_NL;
        end else begin
            o_sts.chr = CHR_TEXT;
        end
        o_sts.tab_more    = (x_inc[TAB_BITS-1:0] != '0) && (x_inc < {1'b0, ew});
        o_sts.need_scroll = need_scroll;
        o_sts.h_one       = (eh == ROW_W'(1));
        o_sts.col_last    = (r_col == ew - COL_W'(1));
        o_sts.row_last    = (r_row == eh - ROW_W'(1));
        o_sts.scr_last    = (({1'b0, r_row} + (ROW_W+1)'(2)) == {1'b0, eh});
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_pos    = r_out_pos;
    assign o_cursor_line   = r_out_line;
    assign o_cursor_column = r_out_col;
    assign o_read_char     = r_out_char;
    assign o_scrolled      = r_out_scrolled;

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr < CELL_AW'(CELLS)))
        else $error("cell write beyond the screen store");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result load did not raise output valid");

endmodule

@@ rtl/core/text_console_char_writer.sv @@
// Text console window writer: top level joining sequencer and datapath.
//
// Input channel (i_in_valid / o_in_ready) takes one command word: put a
// character, read a window cell, or clear the window. Output channel
// (o_out_valid / i_out_ready) returns one result word per command: cursor
// position, line and column, the character read and a scroll flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while no command is in work; not enforced.
// All commands go through one 8-bit cell store port; a scroll copies the
// window rows up, then blanks the bottom row (row copy, then blank). One
// command is in work at a time; the next is taken in the cycle after the
// result loads.
// After reset the store is swept to spaces, one cell a cycle, over all
// 2000 cells; o_in_ready stays low through that sweep.
// The result sits in an output register, so one more command is taken and
// worked while the receiver stalls; it then holds its result, with
// o_in_ready low, until the register is taken.
module text_console_char_writer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]       i_func,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]        i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]        i_read_col,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tcw_pkg::POS_W-1:0]        o_cursor_pos,
    output logic [tcw_pkg::ROW_W-1:0]        o_cursor_line,
    output logic [tcw_pkg::COL_W-1:0]        o_cursor_column,
    output logic [tcw_pkg::CHAR_W-1:0]       o_read_char,
    output logic                             o_scrolled
);
    import tcw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    tcw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_char_code    (i_char_code),
        .i_read_row     (i_read_row),
        .i_read_col     (i_read_col),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_cursor_pos   (o_cursor_pos),
        .o_cursor_line  (o_cursor_line),
        .o_cursor_column(o_cursor_column),
        .o_read_char    (o_read_char),
        .o_scrolled     (o_scrolled),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
